// File: rtl/dbrm_pkg.sv
// Shared types, constants and helper functions of the DRAM bank/row address mapper.
// Used by every module of the mapper except dbrm_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dbrm_pkg;

   localparam int ADDR_W     = 48;
   localparam int BANK_W     = 5;
   localparam int BITS_W     = 6;
   localparam int CNT_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int SH_W       = $clog2(ADDR_W);
   localparam int REQ_DATA_W = ((ADDR_W + BANK_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((BITS_W + 2 * ADDR_W + 7) / 8) * 8;
   localparam int BANK_CODES = 1 << BANK_W;

   localparam int ADDR_BITS_DEF  = 48;
   localparam int MAX_FUNCS_DEF  = 6;
   localparam int BANK_COUNT_DEF = 32;

   localparam logic [CSR_IDX_W-1:0] REG_ROW_MASK = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FN_COUNT = 3'd7;

   localparam logic [ADDR_W-1:0] FN_RESET [BITS_W] = '{
      48'h2040, 48'h24000, 48'h48000, 48'h90000, 48'h0, 48'h0
   };
   localparam logic [ADDR_W-1:0] ROW_MASK_RESET = 48'h3ffe0000;
   localparam logic [CNT_W-1:0]  FN_COUNT_RESET = 3'd4;

   typedef enum logic [0:0] {
      CMD_RECORD    = 1'b0,
      CMD_TRANSLATE = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [BITS_W-1:0][ADDR_W-1:0] fn;
      logic [BITS_W-1:0]             fn_en;
      logic [ADDR_W-1:0]             row_mask;
   } cfg_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [ADDR_W-1:0] addr;
      logic [BITS_W-1:0] bits;
      logic [ADDR_W-1:0] row;
      logic [BITS_W-1:0] sig;
   } qent_type;

   function automatic logic all_or_none(input logic [ADDR_W-1:0] addr,
                                        input logic [ADDR_W-1:0] fn);
      logic [ADDR_W-1:0] m;
      m = addr & fn;
      return (m == '0) || (m == fn);
   endfunction

   function automatic logic [ADDR_W-1:0] lowest_bit(input logic [ADDR_W-1:0] x);
      return x & (~x + ADDR_W'(1));
   endfunction

   function automatic logic [SH_W-1:0] low_pos(input logic [ADDR_W-1:0] m);
      logic [SH_W-1:0] pos;
      pos = '0;
      for (int i = ADDR_W - 1; i >= 0; i--) begin
         if (m[i]) begin
            pos = SH_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

// File: rtl/dbrm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the bank signature table of the mapper.
`timescale 1ns / 1ps
`default_nettype none

module dbrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/dbrm_front.sv
// Front end: accepts requests, computes bank bits and row index, records signatures
// and fetches the stored signature. Depends on dbrm_pkg and dbrm_ram.
`timescale 1ns / 1ps
`default_nettype none

module dbrm_front #(
   parameter int ADDR_BITS  = dbrm_pkg::ADDR_BITS_DEF,
   parameter int BANK_COUNT = dbrm_pkg::BANK_COUNT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [dbrm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                req_tuser,
   input  wire dbrm_pkg::cfg_type                   cfg,
   input  wire logic                                q_full,
   output logic                                     q_push,
   output dbrm_pkg::qent_type                       q_data
);

   import dbrm_pkg::*;

   localparam int EFF_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - EFF_BITS);
   localparam int BIDX_W = $clog2(BANK_COUNT);

   logic [BIDX_W-1:0] bank_map [BANK_CODES];

   for (genvar g = 0; g < BANK_CODES; g++) begin : g_map
      assign bank_map[g] = BIDX_W'(g % BANK_COUNT);
   end

   logic              accept;
   cmd_type           cmd;
   logic [ADDR_W-1:0] addr;
   logic [BIDX_W-1:0] bidx;
   logic [BITS_W-1:0] bits;
   logic              wr_en;
   logic              rd_en;
   logic [BITS_W-1:0] rd_data;

   logic [BANK_COUNT-1:0] valid_ff, valid_in;
   logic              f1_valid_ff, f1_valid_in;
   cmd_type           f1_cmd_ff;
   logic [ADDR_W-1:0] f1_addr_ff;
   logic [BITS_W-1:0] f1_bits_ff;
   logic              f1_hit_ff;

   assign accept = req_tvalid & req_tready;
   assign cmd    = cmd_type'(req_tuser);
   assign addr   = req_tdata[ADDR_W-1:0] & ADDR_MASK;
   assign bidx   = bank_map[req_tdata[ADDR_W +: BANK_W]];

   always_comb begin
      for (int i = 0; i < BITS_W; i++) begin
         bits[i] = cfg.fn_en[i] & ~all_or_none(addr, cfg.fn[i]);
      end
   end

   assign wr_en = accept & (cmd == CMD_RECORD);
   assign rd_en = accept & (cmd == CMD_TRANSLATE);

   dbrm_ram #(
      .WIDTH(BITS_W),
      .DEPTH(BANK_COUNT)
   ) u_sig_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(bidx),
      .wr_data(bits),
      .rd_en  (rd_en),
      .rd_addr(bidx),
      .rd_data(rd_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[bidx] = 1'b1;
      end
   end

   assign req_tready = ~f1_valid_ff | ~q_full;
   assign q_push     = f1_valid_ff & ~q_full;

   always_comb begin
      if (accept) begin
         f1_valid_in = 1'b1;
      end else if (q_push) begin
         f1_valid_in = 1'b0;
      end else begin
         f1_valid_in = f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         f1_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_cmd_ff  <= cmd;
         f1_addr_ff <= addr;
         f1_bits_ff <= bits;
         f1_hit_ff  <= valid_ff[bidx];
      end
   end

   always_comb begin
      q_data.cmd  = f1_cmd_ff;
      q_data.addr = f1_addr_ff;
      q_data.bits = f1_bits_ff;
      q_data.row  = (f1_addr_ff & cfg.row_mask) >> low_pos(cfg.row_mask);
      q_data.sig  = f1_hit_ff ? rd_data : '0;
   end

endmodule

`default_nettype wire

// File: rtl/dbrm_queue.sv
// Four-entry queue between the front end and the back end of the mapper.
// Depends on dbrm_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module dbrm_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire dbrm_pkg::qent_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output dbrm_pkg::qent_type      pop_data,
   output logic                    empty
);

   import dbrm_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   qent_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == (PTR_W + 1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/dbrm_back.sv
// Back end: normalizes translate addresses toward the stored bank signature and
// holds the response register. Depends on dbrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbrm_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire dbrm_pkg::cfg_type               cfg,
   input  wire logic                            q_empty,
   input  wire dbrm_pkg::qent_type              q_data,
   output logic                                 q_pop,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [dbrm_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   import dbrm_pkg::*;

   logic              out_valid_ff, out_valid_in;
   logic [BITS_W-1:0] out_bits_ff;
   logic [ADDR_W-1:0] out_row_ff;
   logic [ADDR_W-1:0] out_norm_ff;
   logic [ADDR_W-1:0] norm;

   always_comb begin
      norm = q_data.addr;
      if (q_data.cmd == CMD_TRANSLATE) begin
         for (int i = 0; i < BITS_W; i++) begin
            if (cfg.fn_en[i] && (q_data.sig[i] == all_or_none(norm, cfg.fn[i]))) begin
               norm = norm ^ lowest_bit(cfg.fn[i]);
            end
         end
      end
   end

   assign q_pop = ~q_empty & (~out_valid_ff | rsp_tready);

   always_comb begin
      if (q_pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_bits_ff <= q_data.bits;
         out_row_ff  <= q_data.row;
         out_norm_ff <= norm;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_norm_ff, out_row_ff, out_bits_ff});

endmodule

`default_nettype wire

// File: rtl/dram_bank_row_address_mapper.sv
// Top level of the DRAM bank/row address mapper: configuration registers and the
// front end, queue and back end. Depends on dbrm_pkg, dbrm_front, dbrm_queue, dbrm_back.
//
//   Channel   Direction  Handshake               Payload
//   req       in         req_tvalid/req_tready   tdata: address, bank; tuser: cmd
//   rsp       out        rsp_tvalid/rsp_tready   tdata: bank_bits, row_index, normalized
//   csr       in         csr_valid/csr_ready     csr_index, csr_data
//
// One request per cycle is accepted unless the front stage and the queue are both full;
// its response passes the front stage, the queue and the response register.
// The bank signature table has one valid bit per entry in flip-flops, so reset
// clears it at once and no clearing pass is needed.
// A four-entry queue between the front end and the back end absorbs response
// stalls; the request side stalls only when the queue and the front stage are full.
`timescale 1ns / 1ps
`default_nettype none

module dram_bank_row_address_mapper #(
   parameter int ADDR_BITS  = dbrm_pkg::ADDR_BITS_DEF,
   parameter int MAX_FUNCS  = dbrm_pkg::MAX_FUNCS_DEF,
   parameter int BANK_COUNT = dbrm_pkg::BANK_COUNT_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // address[47:0], bank[52:48], zero fill
   input  wire logic [dbrm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // bank_bits[5:0], row_index[53:6], normalized_address[101:54], zero fill
   output logic [dbrm_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [dbrm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [dbrm_pkg::ADDR_W-1:0]      csr_data
);

   import dbrm_pkg::*;

   localparam int EFF_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - EFF_BITS);
   localparam int NUM_FN = (MAX_FUNCS < BITS_W) ? MAX_FUNCS : BITS_W;

   logic              csr_we;
   logic [ADDR_W-1:0] row_mask_ff;
   logic [CNT_W-1:0]  fn_count_ff;
   cfg_type           cfg;
   logic              q_push, q_full, q_pop, q_empty;
   qent_type          q_in, q_out;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   for (genvar g = 0; g < BITS_W; g++) begin : g_fn
      if (g < NUM_FN) begin : g_reg
         logic [ADDR_W-1:0] fn_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               fn_ff <= FN_RESET[g];
            end else if (csr_we && (csr_index == CSR_IDX_W'(g))) begin
               fn_ff <= csr_data & ADDR_MASK;
            end
         end
         assign cfg.fn[g]    = fn_ff;
         assign cfg.fn_en[g] = (CNT_W'(g) < fn_count_ff);
      end else begin : g_off
         assign cfg.fn[g]    = '0;
         assign cfg.fn_en[g] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_mask_ff <= ROW_MASK_RESET;
         fn_count_ff <= FN_COUNT_RESET;
      end else if (csr_we) begin
         if (csr_index == REG_ROW_MASK) begin
            row_mask_ff <= csr_data & ADDR_MASK;
         end
         if (csr_index == REG_FN_COUNT) begin
            fn_count_ff <= csr_data[CNT_W-1:0];
         end
      end
   end

   assign cfg.row_mask = row_mask_ff;

   dbrm_front #(
      .ADDR_BITS (ADDR_BITS),
      .BANK_COUNT(BANK_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cfg       (cfg),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   dbrm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_out),
      .empty    (q_empty)
   );

   dbrm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: rtl/dbrm_checker.sv
// Port-level checks of the DRAM bank/row address mapper, bound to its top level.
// Depends on dbrm_pkg and dram_bank_row_address_mapper.
`timescale 1ns / 1ps
`default_nettype none

module dbrm_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [dbrm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic [3:0] MAX_OPEN = 4'd6;

   logic       req_acc;
   logic       rsp_acc;
   logic [3:0] open_ff, open_in;

   assign req_acc = req_tvalid & req_tready;
   assign rsp_acc = rsp_tvalid & rsp_tready;
   assign open_in = open_ff + 4'(req_acc) - 4'(rsp_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Response changed while stalled.");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> open_ff != 4'd0)
      else $error("Response without an outstanding transaction.");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      open_ff <= MAX_OPEN)
      else $error("More transactions in flight than the pipeline holds.");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      open_ff == 4'd0 |-> req_tready)
      else $error("Request side stalled while the block is empty.");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("Response valid right after reset.");

endmodule

bind dram_bank_row_address_mapper dbrm_checker u_dbrm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

`default_nettype wire

// File: sim/dram_bank_row_address_mapper_tb.sv
// Self-checking testbench for the DRAM bank/row address mapper, stream and CSR ports.
// Depends on dbrm_pkg and dram_bank_row_address_mapper; an internal predictor
// computes each expected response, which is compared with the block's output.
`timescale 1ns / 1ps

module dram_bank_row_address_mapper_tb;
   import dbrm_pkg::*;

   localparam int          NFN          = MAX_FUNCS_DEF;
   localparam int          NBANK        = BANK_COUNT_DEF;
   localparam int          SETTLE       = 6;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int          PHASES       = 8;
   localparam int          PHASE_ITEMS  = 150;
   localparam logic [ADDR_W-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic [BITS_W-1:0] bits;
      logic [ADDR_W-1:0] row;
      logic [ADDR_W-1:0] norm;
   } mapping_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [ADDR_W-1:0]       csr_data = '0;

   logic [ADDR_W-1:0]       fn_mask [NFN];
   logic [ADDR_W-1:0]       row_sel;
   logic [CNT_W-1:0]        fn_cnt;
   logic [BITS_W-1:0]       sig_table [NBANK];
   mapping_type             expected_maps [$];

   bit                      gaps_on = 1'b0;
   bit                      stalls_on = 1'b0;
   int unsigned             stall_left = 0;
   int unsigned             cycle_count = 0;
   int unsigned             mismatch_count = 0;
   int unsigned             records = 0;
   int unsigned             translates = 0;
   int unsigned             cfg_writes = 0;
   int unsigned             checked = 0;

   dram_bank_row_address_mapper u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [ADDR_W-1:0] rand48();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[ADDR_W-1:0];
   endfunction

   function automatic int unsigned burst_length();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   always @(posedge clock) begin
      if (reset || !stalls_on) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < 25) begin
            stall_left <= burst_length();
         end
      end
   end

   function automatic logic uniform_under(input logic [ADDR_W-1:0] addr,
                                          input logic [ADDR_W-1:0] mask);
      return ((addr & mask) == '0) || ((addr & mask) == mask);
   endfunction

   function automatic logic [ADDR_W-1:0] row_of(input logic [ADDR_W-1:0] addr);
      int shift;
      shift = 0;
      if (row_sel == '0) begin
         return '0;
      end
      for (int i = ADDR_W - 1; i >= 0; i--) begin
         if (row_sel[i]) begin
            shift = i;
         end
      end
      return (addr & row_sel) >> shift;
   endfunction

   function automatic mapping_type predict_mapping(input cmd_type cmd,
                                                   input logic [ADDR_W-1:0] addr,
                                                   input logic [BANK_W-1:0] bank);
      mapping_type m;
      int n;
      logic [BITS_W-1:0] sig;
      n = (fn_cnt > NFN) ? NFN : int'(fn_cnt);
      m.bits = '0;
      for (int i = 0; i < n; i++) begin
         m.bits[i] = !uniform_under(addr, fn_mask[i]);
      end
      m.row = row_of(addr);
      m.norm = addr;
      if (cmd == CMD_RECORD) begin
         sig_table[bank] = m.bits;
      end else begin
         sig = sig_table[bank];
         for (int i = 0; i < n; i++) begin
            if (sig[i] == uniform_under(m.norm, fn_mask[i])) begin
               m.norm = m.norm ^ (fn_mask[i] & (~fn_mask[i] + ADDR_W'(1)));
            end
         end
      end
      return m;
   endfunction

   task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                  input logic [ADDR_W-1:0] want);
      $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want,
               cycle_count);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_responses
      mapping_type want;
      mapping_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.bits = rsp_tdata[BITS_W-1:0];
         got.row  = rsp_tdata[BITS_W +: ADDR_W];
         got.norm = rsp_tdata[BITS_W + ADDR_W +: ADDR_W];
         if (expected_maps.size() == 0) begin
            report_mismatch("response with none pending", got.norm, '0);
         end else begin
            want = expected_maps.pop_front();
            checked++;
            if (got.bits != want.bits) begin
               report_mismatch("bank_bits", ADDR_W'(got.bits), ADDR_W'(want.bits));
            end
            if (got.row != want.row) begin
               report_mismatch("row_index", got.row, want.row);
            end
            if (got.norm != want.norm) begin
               report_mismatch("normalized_address", got.norm, want.norm);
            end
         end
      end
   end

   task automatic send_item(input cmd_type cmd, input logic [ADDR_W-1:0] addr,
                            input logic [BANK_W-1:0] bank);
      int unsigned gap;
      gap = (gaps_on && $urandom_range(0, 99) < 35) ? burst_length() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({bank, addr});
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_maps.insert(expected_maps.size(), predict_mapping(cmd, addr, bank));
      if (cmd == CMD_RECORD) begin
         records++;
      end else begin
         translates++;
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_maps.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_ROW_MASK) begin
         row_sel = value;
      end else if (idx == REG_FN_COUNT) begin
         fn_cnt = value[CNT_W-1:0];
      end else begin
         fn_mask[idx] = value;
      end
      cfg_writes++;
   endtask

   task automatic load_config(input logic [ADDR_W-1:0] fns [NFN],
                              input logic [ADDR_W-1:0] rows, input logic [CNT_W-1:0] count);
      for (int i = 0; i < NFN; i++) begin
         write_reg(CSR_IDX_W'(i), fns[i]);
      end
      write_reg(REG_ROW_MASK, rows);
      write_reg(REG_FN_COUNT, ADDR_W'({rand48() >> CNT_W, count}));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [ADDR_W-1:0] random_fn_mask();
      logic [ADDR_W-1:0] m;
      int pick;
      m = '0;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         return '0;
      end else if (pick < 15) begin
         return ALL_ONES;
      end else if (pick < 25) begin
         return ADDR_W'(1) << $urandom_range(0, ADDR_W - 1);
      end else if (pick < 40) begin
         return rand48();
      end
      repeat ($urandom_range(2, 4)) m[$urandom_range(6, 35)] = 1'b1;
      return m;
   endfunction

   function automatic logic [ADDR_W-1:0] random_row_mask();
      int lo;
      int hi;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         return '0;
      end else if (pick < 14) begin
         return ALL_ONES;
      end else if (pick < 24) begin
         return rand48();
      end
      lo = $urandom_range(0, ADDR_W - 1);
      hi = $urandom_range(lo, ADDR_W - 1);
      return (ALL_ONES >> (ADDR_W - 1 - hi)) & (ALL_ONES << lo);
   endfunction

   // Addresses are often forced all-set or all-clear under one function so that
   // the uniform case of the bank test is hit as often as the mixed one.
   function automatic logic [ADDR_W-1:0] random_address();
      logic [ADDR_W-1:0] a;
      int k;
      int pick;
      a = rand48();
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, NFN - 1);
      if (pick < 3) begin
         return '0;
      end else if (pick < 6) begin
         return ALL_ONES;
      end else if (pick < 30) begin
         return a | fn_mask[k];
      end else if (pick < 50) begin
         return a & ~fn_mask[k];
      end
      return a;
   endfunction

   task automatic test_reset_mapping();
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      send_item(CMD_TRANSLATE, '0, 5'd0);
      send_item(CMD_RECORD, ALL_ONES, 5'd31);
      send_item(CMD_RECORD, 48'h2000, 5'd5);
      send_item(CMD_TRANSLATE, 48'h1234_5678_9abc, 5'd5);
      send_item(CMD_TRANSLATE, ALL_ONES, 5'd5);
      send_item(CMD_RECORD, 48'h24040, 5'd0);
      send_item(CMD_TRANSLATE, '0, 5'd31);
      drain();
   endtask

   task automatic test_special_cases();
      logic [ADDR_W-1:0] fns [NFN];
      fns = '{ALL_ONES, 48'h0, 48'h8000_0000_0000, 48'h3, 48'h8000_0000_0001, 48'hf00};
      load_config(fns, '0, 3'd7);
      send_item(CMD_RECORD, '0, 5'd1);
      send_item(CMD_RECORD, ALL_ONES, 5'd2);
      send_item(CMD_RECORD, 48'h5555_5555_5555, 5'd3);
      send_item(CMD_TRANSLATE, 48'haaaa_aaaa_aaaa, 5'd3);
      send_item(CMD_TRANSLATE, ALL_ONES, 5'd1);
      send_item(CMD_TRANSLATE, '0, 5'd2);
      drain();
      load_config(fns, ALL_ONES, 3'd0);
      send_item(CMD_TRANSLATE, 48'hdead_beef_0123, 5'd3);
      drain();
      load_config(fns, 48'h8000_0000_0000, 3'd6);
      send_item(CMD_TRANSLATE, ALL_ONES, 5'd31);
      send_item(CMD_RECORD, 48'h8000_0000_0f01, 5'd31);
      drain();
   endtask

   task automatic test_count_change();
      logic [ADDR_W-1:0] fns [NFN];
      fns = '{48'h2040, 48'h24000, 48'h48000, 48'h90000, 48'h300000, 48'hc00000};
      load_config(fns, 48'h3ffe0000, 3'd6);
      send_item(CMD_RECORD, 48'h2a_5000, 5'd7);
      send_item(CMD_TRANSLATE, 48'h1_0000_0000, 5'd7);
      drain();
      load_config(fns, 48'h3ffe0000, 3'd2);
      send_item(CMD_TRANSLATE, 48'h1_0000_0000, 5'd7);
      send_item(CMD_TRANSLATE, ALL_ONES, 5'd7);
      drain();
   endtask

   task automatic test_random_mapping();
      logic [ADDR_W-1:0] fns [NFN];
      logic [BANK_W-1:0] bank;
      int sent;
      int pick;
      for (int phase = 0; phase < PHASES; phase++) begin
         for (int i = 0; i < NFN; i++) begin
            fns[i] = random_fn_mask();
         end
         load_config(fns, random_row_mask(), CNT_W'($urandom_range(0, 7)));
         gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
         stalls_on = (phase != 0) && ($urandom_range(0, 3) != 0);
         sent = 0;
         for (int b = 0; b < NBANK; b++) begin
            send_item(CMD_RECORD, random_address(), BANK_W'(b));
            sent++;
         end
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            bank = BANK_W'($urandom_range(0, NBANK - 1));
            if (pick < 75) begin
               send_item(CMD_TRANSLATE, random_address(), bank);
            end else if (pick < 90) begin
               send_item(CMD_RECORD, random_address(), bank);
            end else begin
               send_item(cmd_type'($urandom_range(0, 1)), rand48(), bank);
            end
            sent++;
         end
         drain();
      end
   endtask

   initial begin
      for (int i = 0; i < NFN; i++) begin
         fn_mask[i] = FN_RESET[i];
      end
      row_sel = ROW_MASK_RESET;
      fn_cnt = FN_COUNT_RESET;
      for (int i = 0; i < NBANK; i++) begin
         sig_table[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_mapping();
      test_special_cases();
      test_count_change();
      test_random_mapping();
      if (expected_maps.size() != 0) begin
         report_mismatch("responses never arrived", ADDR_W'(expected_maps.size()), '0);
      end
      $display("Ran %0d record and %0d translate transactions under %0d register writes,",
               records, translates, cfg_writes);
      $display("with reset, corner-case and %0d random mask settings; %0d responses checked.",
               PHASES, checked);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
